// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RPFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpfa assertion failed");

// next-cycle implication, disabled while in reset
`define RPFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpfa assertion failed");

`endif

// ===== rtl/rpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfa_pkg
// types and constants of the refcounted page frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpfa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int PAGE_BYTES = 4096;

	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 16;
	localparam int PAGE_IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int OFFSET_W   = $clog2(PAGE_BYTES);
	localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
	localparam int PFULL_W    = ADDR_W - OFFSET_W;

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_ADD   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BADADDR  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      op;
		logic [ADDR_W-1:0]        address;
		logic signed [CNT_W-1:0]  delta;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]        page_address;
		logic signed [CNT_W-1:0]  ref_count;
		logic                     page_released;
		status_t                  status;
	} rsp_t;

	// commit of one stack update
	typedef struct packed {
		logic                  pop;
		logic                  push;
		logic [PAGE_IDX_W-1:0] push_idx;
	} stack_cmd_t;

	// write into the count store
	typedef struct packed {
		logic                    en;
		logic [PAGE_IDX_W-1:0]   idx;
		logic signed [CNT_W-1:0] value;
	} cnt_wr_t;

endpackage

// ===== rtl/refcounted_page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_core
// page frame allocator: lifo free stack plus signed per-page reference counts
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     req (op, address, delta)
//   rsp       out        rsp_valid / rsp_stall     rsp (page_address, ref_count,
//                                                  page_released, status)
//   cfg       in         cfg_wr_en                 cfg_wr_data (lowest free address)
//
// each transaction: the accept edge launches the count and stack memory reads, and
//   the edge that completes stage 1 writes both memories and the result register
// one transaction in flight at a time, since the next one may hit the same count
// after reset the count memory is swept to zero, one entry per cycle;
//   req_stall stays high for the sweep
// a result waiting under rsp_stall holds the stage, so req_stall stays high too
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module refcounted_page_frame_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rpfa_pkg::ADDR_W-1:0]  cfg_wr_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  rpfa_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output rpfa_pkg::rsp_t               rsp
);
	import rpfa_pkg::*;

	// config
	logic [ADDR_W-1:0] lowest_free_address_q;

	// stage 1 request register
	logic                    s1_valid_q;
	op_t                     op_s1;
	logic [ADDR_W-1:0]       address_s1;
	logic signed [CNT_W-1:0] delta_s1;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// memory side
	logic                    clearing;
	logic                    accept;
	logic                    s1_done;
	logic [PAGE_IDX_W-1:0]   rd_idx;
	logic signed [CNT_W-1:0] cnt_rd;
	logic [PAGE_IDX_W-1:0]   top_idx;
	logic [DEPTH_W-1:0]      depth;
	stack_cmd_t              stack_cmd;
	cnt_wr_t                 cnt_wr;

	// stage 1 decode
	logic [PFULL_W-1:0]      page_full;
	logic [PAGE_IDX_W-1:0]   page_idx;
	logic                    page_ok;
	logic                    aligned;
	logic                    above_low;
	logic signed [CNT_W-1:0] cnt_dec;
	logic signed [CNT_W:0]   sum_wide;
	logic signed [CNT_W-1:0] cnt_sum;
	rsp_t                    rsp_d;
	stack_cmd_t              stack_d;
	cnt_wr_t                 cnt_d;

	// ---------------------------------------------------------------- handshake
	assign req_stall = s1_valid_q | clearing;
	assign accept    = req_valid & ~req_stall;
	assign s1_done   = s1_valid_q & (~rsp_valid_q | ~rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_free_address_q <= '0;
		end else if (cfg_wr_en) begin
			lowest_free_address_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= req.op;
			address_s1 <= req.address;
			delta_s1   <= req.delta;
		end
	end

	// ---------------------------------------------------------------- memories
	// count read is launched straight from the request payload on the accept edge
	assign rd_idx = PAGE_IDX_W'(req.address >> OFFSET_W);

	rpfa_count_store u_count_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (rd_idx),
		.wr       (cnt_wr),
		.rd_data  (cnt_rd),
		.clearing (clearing)
	);

	rpfa_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.cmd     (stack_cmd),
		.top_idx (top_idx),
		.depth   (depth)
	);

	// ---------------------------------------------------------------- stage 1 op
	assign page_full = address_s1[ADDR_W-1:OFFSET_W];
	assign page_idx  = PAGE_IDX_W'(page_full);
	// page index range check, one bit wider so the page count itself fits
	assign page_ok   = {1'b0, page_full} < (PFULL_W + 1)'(NUM_PAGES);
	assign aligned   = address_s1[OFFSET_W-1:0] == '0;
	assign above_low = address_s1 >= lowest_free_address_q;

	// saturating decrement and add
	assign cnt_dec  = (cnt_rd == CNT_MIN) ? CNT_MIN : (cnt_rd - CNT_ONE);
	assign sum_wide = {cnt_rd[CNT_W-1], cnt_rd} + {delta_s1[CNT_W-1], delta_s1};
	always_comb begin
		if (sum_wide[CNT_W] != sum_wide[CNT_W-1]) begin
			cnt_sum = sum_wide[CNT_W] ? CNT_MIN : CNT_MAX;
		end else begin
			cnt_sum = sum_wide[CNT_W-1:0];
		end
	end

	always_comb begin
		rsp_d.page_address  = '0;
		rsp_d.ref_count     = '0;
		rsp_d.page_released = 1'b0;
		rsp_d.status        = ST_OK;
		stack_d.pop         = 1'b0;
		stack_d.push        = 1'b0;
		stack_d.push_idx    = page_idx;
		cnt_d.en            = 1'b0;
		cnt_d.idx           = page_idx;
		cnt_d.value         = cnt_rd;
		case (op_s1)
			OP_ALLOC: begin
				if (depth == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					// popped page gets a fresh count of one
					stack_d.pop        = 1'b1;
					cnt_d.en           = 1'b1;
					cnt_d.idx          = top_idx;
					cnt_d.value        = CNT_ONE;
					rsp_d.page_address = ADDR_W'({top_idx, {OFFSET_W{1'b0}}});
					rsp_d.ref_count    = CNT_ONE;
				end
			end
			OP_FREE: begin
				if (!aligned || !above_low || !page_ok) begin
					rsp_d.status = ST_BADADDR;
				end else begin
					cnt_d.en        = 1'b1;
					cnt_d.value     = cnt_dec;
					rsp_d.ref_count = cnt_dec;
					if (cnt_dec == '0) begin
						// count reached zero: back onto the stack unless it is full
						if (depth >= DEPTH_W'(NUM_PAGES)) begin
							rsp_d.status = ST_OVERFLOW;
						end else begin
							stack_d.push        = 1'b1;
							rsp_d.page_released = 1'b1;
						end
					end
				end
			end
			OP_ADD: begin
				if (!page_ok) begin
					rsp_d.status = ST_BADADDR;
				end else begin
					cnt_d.en        = 1'b1;
					cnt_d.value     = cnt_sum;
					rsp_d.ref_count = cnt_sum;
				end
			end
			default: begin
				// read count, low address bits ignored
				if (!page_ok) begin
					rsp_d.status = ST_BADADDR;
				end else begin
					rsp_d.ref_count = cnt_rd;
				end
			end
		endcase
	end

	// memory updates commit only when the result can be registered
	always_comb begin
		stack_cmd      = stack_d;
		stack_cmd.pop  = stack_d.pop & s1_done;
		stack_cmd.push = stack_d.push & s1_done;
		cnt_wr         = cnt_d;
		cnt_wr.en      = cnt_d.en & s1_done;
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RPFA_ASSERT_NXT(a_accept_loads_s1, clk, arst_n, accept, s1_valid_q)
	`RPFA_ASSERT_NXT(a_done_gives_rsp, clk, arst_n, s1_done, rsp_valid_q)

endmodule

// ===== rtl/rpfa_free_stack.sv =====
// ----------------------------------------------------------------------------
// rpfa_free_stack
// lifo of free page indices with a registered top-of-stack read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpfa_free_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  rpfa_pkg::stack_cmd_t           cmd,
	output logic [rpfa_pkg::PAGE_IDX_W-1:0] top_idx,
	output logic [rpfa_pkg::DEPTH_W-1:0]    depth
);
	import rpfa_pkg::*;

	logic [PAGE_IDX_W-1:0] mem [NUM_PAGES];
	logic [DEPTH_W-1:0]    depth_q;
	logic [DEPTH_W-1:0]    depth_m1;
	logic [PAGE_IDX_W-1:0] top_q;

	assign depth_m1 = depth_q - DEPTH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.pop) begin
			depth_q <= depth_m1;
		end else if (cmd.push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end
	end

	// read of an empty stack wraps to the last entry; its data is never used
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[depth_q[PAGE_IDX_W-1:0]] <= cmd.push_idx;
		end
		if (rd_en) begin
			top_q <= mem[depth_m1[PAGE_IDX_W-1:0]];
		end
	end

	assign top_idx = top_q;
	assign depth   = depth_q;

	`RPFA_ASSERT_IMP(a_no_pop_empty, clk, arst_n, cmd.pop, depth_q != '0)
	`RPFA_ASSERT_IMP(a_no_push_full, clk, arst_n, cmd.push, depth_q < DEPTH_W'(NUM_PAGES))
	`RPFA_ASSERT_IMP(a_one_update, clk, arst_n, cmd.pop, !cmd.push)

endmodule

// ===== rtl/rpfa_count_store.sv =====
// ----------------------------------------------------------------------------
// rpfa_count_store
// per-page reference counts with a clearing sweep after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpfa_count_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [rpfa_pkg::PAGE_IDX_W-1:0]  rd_idx,
	input  rpfa_pkg::cnt_wr_t                wr,
	output logic signed [rpfa_pkg::CNT_W-1:0] rd_data,
	output logic                             clearing
);
	import rpfa_pkg::*;

	logic signed [CNT_W-1:0] mem [NUM_PAGES];
	logic                    clearing_q;
	logic [PAGE_IDX_W-1:0]   clr_idx_q;
	logic signed [CNT_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + PAGE_IDX_W'(1);
			if (clr_idx_q == PAGE_IDX_W'(NUM_PAGES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem[wr.idx] <= wr.value;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_data  = rd_q;
	assign clearing = clearing_q;

	`RPFA_ASSERT_IMP(a_no_access_in_sweep, clk, arst_n, clearing_q, !wr.en && !rd_en)

endmodule
